FILE: rtl/efr_pkg.sv
package efr_pkg;

   localparam int BYTE_W = 8;
   localparam int IDX_W  = 4;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [IDX_W-1:0]  idx_type;

   // framing codes on the serial line
   localparam byte_type BYTE_START = 8'hFD;
   localparam byte_type BYTE_END   = 8'hF8;
   localparam byte_type BYTE_ESC   = 8'hFE;

   // escaped byte decode: low nibble kept, high nibble forced on
   localparam byte_type LOW_NIBBLE = 8'h0F;
   localparam byte_type HIGH_SET   = 8'hF0;

endpackage

FILE: rtl/efr_cell.sv
module efr_cell
   import efr_pkg::*;
(
   input  logic     clock,
   input  logic     shift_en,
   input  byte_type data_in,
   output byte_type data_out
);

   byte_type data_ff;

   // one stored byte, moves one place towards the head on every shift
   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

FILE: rtl/escaped_byte_frame_receiver.sv
// Byte-stuffed frame receiver. Serial bytes arrive on the req_ channel, one per
// transaction. 0xFD opens a frame and is kept as its first byte, 0xFE escapes
// the following byte (stored as its low nibble with the high nibble set, even
// when that gives 0xFE again), and 0xF8 closes the frame. A pending escape is
// kept across the end of a frame and into the next one. When a frame closes
// with exactly FRAME_LEN-1 bytes stored, those bytes stream out on the rsp_
// channel in arrival order, one per transaction, with their position (low four
// bits) and a last mark on the final byte; any other closing discards the
// frame, and a frame that reaches FRAME_LEN bytes is dropped on the spot.
// A byte is taken whenever req_valid is high and req_stall is low. An end byte
// that completes a good frame starts a burst of FRAME_LEN-1 result
// transactions, one per cycle when the receiver does not stall, and req_stall
// is held high for that burst. The figure is set by the chain of byte cells,
// which collect the frame and shift it out, a place per stored or sent byte.
module escaped_byte_frame_receiver
   import efr_pkg::*;
#(
   parameter int FRAME_LEN = 14
)
(
   input  logic     clock,
   input  logic     reset,

   input  logic     req_valid,
   output logic     req_stall,
   input  byte_type req_rx_byte,

   output logic     rsp_valid,
   input  logic     rsp_stall,
   output byte_type rsp_frame_byte,
   output idx_type  rsp_byte_index,
   output logic     rsp_last
);

   // a delivered frame holds one byte fewer than the overflow limit
   localparam int CHAIN_LEN = FRAME_LEN - 1;
   localparam int FILL_W    = $clog2(FRAME_LEN + 1);
   localparam int EMIT_W    = $clog2(CHAIN_LEN);

   typedef logic [FILL_W-1:0] fill_type;
   typedef logic [EMIT_W-1:0] emit_type;

   // framing state
   logic     in_frame_ff, in_frame_in;
   logic     esc_ff, esc_in;
   fill_type fill_ff, fill_in;

   // burst sequencing
   logic     burst_ff, burst_in;
   emit_type emit_idx_ff, emit_idx_in;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type rsp_frame_byte_ff;
   idx_type  rsp_byte_index_ff;
   logic     rsp_last_ff;

   logic     req_take;
   logic     is_start, is_end, is_esc;
   logic     store;
   logic     start_burst;
   logic     emit_step;
   logic     emit_last;
   logic     chain_shift;
   byte_type tail_byte;
   byte_type chain_q [CHAIN_LEN];

   // no new bytes while a frame is streaming out
   assign req_stall = burst_ff;
   assign req_take  = req_valid && !burst_ff;

   assign is_start = (req_rx_byte == BYTE_START);
   assign is_end   = (req_rx_byte == BYTE_END);
   assign is_esc   = (req_rx_byte == BYTE_ESC);

   // byte entering the tail of the chain, decoded when an escape is pending
   assign tail_byte = esc_ff ? ((req_rx_byte & LOW_NIBBLE) | HIGH_SET) : req_rx_byte;

   // framing decisions for one accepted byte
   always_comb begin
      logic     frame_open;
      fill_type fill_base;
      fill_type fill_next;

      frame_open  = is_start || in_frame_ff;
      fill_base   = is_start ? '0 : fill_ff;
      fill_next   = fill_base + 1'b1;

      in_frame_in = in_frame_ff;
      fill_in     = fill_ff;
      esc_in      = esc_ff;
      store       = 1'b0;
      start_burst = 1'b0;

      if (req_take) begin
         if (is_end) begin
            // close the frame, deliver only at exactly the expected length
            start_burst = (fill_ff == FILL_W'(CHAIN_LEN));
            in_frame_in = 1'b0;
            fill_in     = '0;
         end else if (frame_open) begin
            in_frame_in = 1'b1;
            fill_in     = fill_base;
            if (esc_ff) begin
               esc_in = 1'b0;
               store  = 1'b1;
            end else if (is_esc) begin
               esc_in = 1'b1;
            end else begin
               store  = 1'b1;
            end
            if (store) begin
               if (fill_next == FILL_W'(FRAME_LEN)) begin
                  // overflow: drop the frame
                  in_frame_in = 1'b0;
                  fill_in     = '0;
               end else begin
                  fill_in     = fill_next;
               end
            end
         end
      end
   end

   // burst: move the head of the chain into the output register when free
   assign emit_step   = burst_ff && (!rsp_valid_ff || !rsp_stall);
   assign emit_last   = (emit_idx_ff == EMIT_W'(CHAIN_LEN - 1));
   assign chain_shift = store || emit_step;

   always_comb begin
      burst_in    = burst_ff;
      emit_idx_in = emit_idx_ff;
      if (start_burst) begin
         burst_in    = 1'b1;
         emit_idx_in = '0;
      end else if (emit_step) begin
         emit_idx_in = emit_idx_ff + 1'b1;
         if (emit_last) begin
            burst_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // chain of byte cells: new bytes enter at the tail, the head feeds the output
   for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
      if (k == CHAIN_LEN - 1) begin : g_tail
         efr_cell u_cell (
            .clock    (clock),
            .shift_en (chain_shift),
            .data_in  (tail_byte),
            .data_out (chain_q[k])
         );
      end else begin : g_body
         efr_cell u_cell (
            .clock    (clock),
            .shift_en (chain_shift),
            .data_in  (chain_q[k+1]),
            .data_out (chain_q[k])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         esc_ff       <= 1'b0;
         fill_ff      <= '0;
         burst_ff     <= 1'b0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         esc_ff       <= esc_in;
         fill_ff      <= fill_in;
         burst_ff     <= burst_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload, only loaded with a fresh byte
   always_ff @(posedge clock) begin
      if (emit_step) begin
         rsp_frame_byte_ff <= chain_q[0];
         rsp_byte_index_ff <= IDX_W'(emit_idx_ff);
         rsp_last_ff       <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_byte_index = rsp_byte_index_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: rtl/efr_checker.sv
module efr_checker
   import efr_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_stall,
   input logic     rsp_valid,
   input logic     rsp_stall,
   input byte_type rsp_frame_byte,
   input idx_type  rsp_byte_index,
   input logic     rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_byte_index) && $stable(rsp_last))
      else $error("stalled result changed");

   // a burst runs without gaps until its last byte
   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a frame burst");

   // positions count up by one within a burst
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_byte_index == idx_type'($past(rsp_byte_index) + 1'b1))
      else $error("byte index did not advance");

   // input is held off while a burst is still streaming
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken during a burst");

endmodule

bind escaped_byte_frame_receiver efr_checker u_efr_checker (.*);
